### design/rhpm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhpm_pkg
// Shared types and constants of the rolling hash pattern match counter.
// ----------------------------------------------------------------------------
package rhpm_pkg;

    localparam int BYTE_W     = 8;
    localparam int PAT_BYTES  = 32;
    localparam int PAT_W      = PAT_BYTES * BYTE_W;
    localparam int LEN_REG_W  = 6;
    localparam int APB_ADDR_W = 6;
    localparam int APB_DATA_W = 64;
    localparam int REG_IDX_W  = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int TOTAL_W    = 32;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_LENGTH  = 3'd0,
        REG_PAT_LO  = 3'd1,
        REG_PAT_MLO = 3'd2,
        REG_PAT_MHI = 3'd3,
        REG_PAT_HI  = 3'd4
    } reg_idx_t;

    typedef logic [PAT_W-1:0] pattern_t;

    // classified word passed from the front to the back
    typedef struct packed {
        logic match;
        logic last;
    } rhpm_word_t;

endpackage

### design/rolling_hash_pattern_match_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rolling_hash_pattern_match_counter
// Counts exact overlapping occurrences of a configured pattern in a byte
// stream; one result word per text byte.
// ----------------------------------------------------------------------------
// Path: an accepted byte is classified in the front and written into the
//   queue, then the back moves it into the result register.
// Throughput: one byte per cycle while the queue has room, set by the window
//   compare in the front and the counter update in the back.
// Reset: text state cleared, pattern_length reads 1, pattern bytes read 0.
module rolling_hash_pattern_match_counter #(
    parameter int MAX_PATTERN = 32,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [rhpm_pkg::BYTE_W-1:0]     text_byte,
    input  logic                            last_byte,
    output logic                            empty,
    input  logic                            pop,
    output logic                            match_ends_here,
    output logic [rhpm_pkg::TOTAL_W-1:0]    match_total,
    output logic                            text_done,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rhpm_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [rhpm_pkg::APB_DATA_W-1:0] pwdata,
    output logic [rhpm_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import rhpm_pkg::*;

    logic [LEN_REG_W-1:0]  length_reg;
    logic [APB_DATA_W-1:0] pat_reg [4];
    logic                  cfg_wr;
    reg_idx_t              idx;
    logic                  len_clear;
    pattern_t              pattern;

    logic                  q_full;
    logic                  q_wr;
    rhpm_word_t            q_wdata;
    logic                  q_rd;
    rhpm_word_t            q_rdata;
    logic                  q_nonempty;

    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite;
    assign idx       = reg_idx_t'(paddr[APB_ADDR_W-1 -: REG_IDX_W]);
    assign len_clear = cfg_wr && (idx == REG_LENGTH);
    assign pattern   = {pat_reg[3], pat_reg[2], pat_reg[1], pat_reg[0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg <= LEN_REG_W'(1);
            for (int i = 0; i < 4; i++)
            begin
                pat_reg[i] <= '0;
            end
        end
        else if (cfg_wr)
        begin
            unique case (idx)
                REG_LENGTH:  length_reg <= pwdata[LEN_REG_W-1:0];
                REG_PAT_LO:  pat_reg[0] <= pwdata;
                REG_PAT_MLO: pat_reg[1] <= pwdata;
                REG_PAT_MHI: pat_reg[2] <= pwdata;
                REG_PAT_HI:  pat_reg[3] <= pwdata;
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_LENGTH:  prdata = APB_DATA_W'(length_reg);
            REG_PAT_LO:  prdata = pat_reg[0];
            REG_PAT_MLO: prdata = pat_reg[1];
            REG_PAT_MHI: prdata = pat_reg[2];
            REG_PAT_HI:  prdata = pat_reg[3];
            default:     prdata = '0;
        endcase
    end

    rhpm_front #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .clear          (len_clear),
        .pattern_length (length_reg),
        .pattern        (pattern),
        .push           (push),
        .text_byte      (text_byte),
        .last_byte      (last_byte),
        .q_full         (q_full),
        .full           (full),
        .q_wr           (q_wr),
        .q_wdata        (q_wdata)
    );

    rhpm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (q_wr),
        .wdata    (q_wdata),
        .full     (q_full),
        .rd       (q_rd),
        .rdata    (q_rdata),
        .nonempty (q_nonempty)
    );

    rhpm_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .clear           (len_clear),
        .q_nonempty      (q_nonempty),
        .q_rdata         (q_rdata),
        .q_rd            (q_rd),
        .pop             (pop),
        .empty           (empty),
        .match_ends_here (match_ends_here),
        .match_total     (match_total),
        .text_done       (text_done)
    );

endmodule

### design/rhpm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhpm_front
// Accepts text bytes, keeps the aligned window and classifies each byte as
// match or no match by a parallel compare against the pattern.
// ----------------------------------------------------------------------------
module rhpm_front #(
    parameter int MAX_PATTERN = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           clear,
    input  logic [rhpm_pkg::LEN_REG_W-1:0] pattern_length,
    input  rhpm_pkg::pattern_t             pattern,
    input  logic                           push,
    input  logic [rhpm_pkg::BYTE_W-1:0]    text_byte,
    input  logic                           last_byte,
    input  logic                           q_full,
    output logic                           full,
    output logic                           q_wr,
    output rhpm_pkg::rhpm_word_t           q_wdata
);
    import rhpm_pkg::*;

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);

    // window aligned to the pattern: entry i is compared with pattern byte i,
    // the newest byte enters at entry len-1
    logic [BYTE_W-1:0] align_reg  [MAX_PATTERN];
    logic [BYTE_W-1:0] align_next [MAX_PATTERN];
    logic [LEN_W-1:0]  seen_reg;
    logic [LEN_W-1:0]  seen_next;
    logic [LEN_W-1:0]  len_eff;
    logic [LEN_W-1:0]  len_m1;
    logic [6:0]        len_raw7;
    logic [MAX_PATTERN-1:0] pos_ok;
    logic              accept;

    always_comb
    begin
        len_raw7 = 7'(pattern_length);
        priority if (len_raw7 == 7'd0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (len_raw7 > 7'(MAX_PATTERN))
        begin
            len_eff = LEN_W'(MAX_PATTERN);
        end
        else
        begin
            len_eff = LEN_W'(len_raw7);
        end
        len_m1 = len_eff - LEN_W'(1);
    end

    assign full   = q_full;
    assign accept = push && !q_full;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_PATTERN; gi++)
        begin : g_win
            logic [BYTE_W-1:0] pat_b;
            if (gi < PAT_BYTES)
            begin : g_pat
                assign pat_b = pattern[gi*BYTE_W +: BYTE_W];
            end
            else
            begin : g_zero
                assign pat_b = '0;
            end

            if (gi < MAX_PATTERN - 1)
            begin : g_shift
                assign align_next[gi] = (LEN_W'(gi) == len_m1) ? text_byte
                                                               : align_reg[gi+1];
            end
            else
            begin : g_end
                assign align_next[gi] = text_byte;
            end

            assign pos_ok[gi] = (LEN_W'(gi) >= len_eff) || (align_next[gi] == pat_b);
        end
    endgenerate

    always_comb
    begin
        seen_next = (seen_reg < len_eff) ? seen_reg + LEN_W'(1) : seen_reg;
    end

    assign q_wr          = accept;
    assign q_wdata.match = (&pos_ok) && (seen_next == len_eff);
    assign q_wdata.last  = last_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
        end
        else if (clear)
        begin
            seen_reg <= '0;
        end
        else if (accept)
        begin
            seen_reg <= last_byte ? '0 : seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < MAX_PATTERN; i++)
            begin
                align_reg[i] <= align_next[i];
            end
        end
    end

endmodule

### design/rhpm_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhpm_queue
// Short queue of classified words between the front and the back.
// ----------------------------------------------------------------------------
module rhpm_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr,
    input  rhpm_pkg::rhpm_word_t wdata,
    output logic                 full,
    input  logic                 rd,
    output rhpm_pkg::rhpm_word_t rdata,
    output logic                 nonempty
);
    import rhpm_pkg::*;

    rhpm_word_t        mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wptr_reg;
    logic [QPTR_W-1:0] rptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign nonempty = (count_reg != '0);
    assign rdata    = mem_reg[rptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (wr && !rd)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (rd && !wr)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (wr)
            begin
                wptr_reg <= wptr_reg + QPTR_W'(1);
            end
            if (rd)
            begin
                rptr_reg <= rptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

endmodule

### design/rhpm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhpm_back
// Takes classified words, keeps the saturating match count and holds the
// result word for the consumer.
// ----------------------------------------------------------------------------
module rhpm_back #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         clear,
    input  logic                         q_nonempty,
    input  rhpm_pkg::rhpm_word_t         q_rdata,
    output logic                         q_rd,
    input  logic                         pop,
    output logic                         empty,
    output logic                         match_ends_here,
    output logic [rhpm_pkg::TOTAL_W-1:0] match_total,
    output logic                         text_done
);
    import rhpm_pkg::*;

    logic [COUNT_WIDTH-1:0] cnt_reg;
    logic [COUNT_WIDTH-1:0] cnt_inc;
    logic                   out_valid_reg;
    logic                   match_reg;
    logic [TOTAL_W-1:0]     total_reg;
    logic                   done_reg;
    logic                   take;

    // advance when the result slot is free or being drained this cycle
    assign take = q_nonempty && (!out_valid_reg || pop);
    assign q_rd = take;

    assign cnt_inc = (q_rdata.match && (cnt_reg != '1)) ? cnt_reg + COUNT_WIDTH'(1)
                                                         : cnt_reg;

    assign empty           = !out_valid_reg;
    assign match_ends_here = match_reg;
    assign match_total     = total_reg;
    assign text_done       = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end

            if (clear)
            begin
                cnt_reg <= '0;
            end
            else if (take)
            begin
                cnt_reg <= q_rdata.last ? '0 : cnt_inc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            match_reg <= q_rdata.match;
            total_reg <= TOTAL_W'(cnt_inc);
            done_reg  <= q_rdata.last;
        end
    end

`ifndef SYNTHESIS
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (take && q_rdata.last) |=> (cnt_reg == '0))
        else $error("count not cleared after final word");

    a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !q_rdata.last && !clear) |=> (cnt_reg >= $past(cnt_reg)))
        else $error("match count went backward within a text");

    a_take_fills: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> out_valid_reg)
        else $error("taken word did not reach the result slot");
`endif

endmodule
